>>> rtl/tcce_pkg.sv
// Shared types and constants for the text console cursor engine.
`timescale 1ns / 1ps

package tcce_pkg;

    // Opcodes
    localparam logic [1:0] OP_KEY   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Key kinds
    localparam logic [1:0] KEY_CHAR  = 2'd0;
    localparam logic [1:0] KEY_ENTER = 2'd1;
    localparam logic [1:0] KEY_BKSP  = 2'd2;

    // Character codes with special handling
    localparam logic [7:0] CH_NONE = 8'd0;
    localparam logic [7:0] CH_CR   = 8'd13;

    // Attribute byte after reset
    localparam logic [7:0] TEXT_COLOR_RST = 8'd15;

    // Request payload
    typedef struct packed {
        logic [1:0] opcode;
        logic [1:0] key_kind;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } t_req;

    // Result payload
    typedef struct packed {
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic        scrolled;
        logic [15:0] cell_data;
    } t_res;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_WRAP,
        S_KEY,
        S_SWEEP,
        S_PUT,
        S_READ,
        S_CLEAR,
        S_DONE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic cap;         // latch the request
        logic nl;          // new line, scroll at the bottom row
        logic bksp;        // step back and blank the cell
        logic sweep_init;  // reset the row blanking counter
        logic sweep;       // blank one cell of the cursor row
        logic put;         // store the typed character
        logic rd;          // read a cell
        logic clear;       // clear screen and home the cursor
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] opcode;
        logic [1:0] key_kind;
        logic       char_zero;
        logic       wrap_pending;
        logic       col_zero;
        logic       row_valid;
        logic       sweep_last;
    } t_stat;

endpackage

>>> rtl/tcce_ctrl.sv
// Sequencing state machine of the text console cursor engine.
`timescale 1ns / 1ps

module tcce_ctrl
    import tcce_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy,
    output logic  o_res_valid
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_DECODE;
            end
            S_DECODE: begin
                unique case (i_stat.opcode)
                    OP_KEY:   n_state = i_stat.wrap_pending ? S_WRAP : S_KEY;
                    OP_READ:  n_state = S_READ;
                    OP_CLEAR: n_state = S_CLEAR;
                    default:  n_state = S_DONE;
                endcase
            end
            S_WRAP: begin
                n_state = S_KEY;
            end
            S_KEY: begin
                unique case (i_stat.key_kind) inside
                    KEY_ENTER, KEY_BKSP: n_state = S_DONE;
                    default: begin
                        if (i_stat.char_zero) n_state = S_DONE;
                        else if (i_stat.row_valid) n_state = S_PUT;
                        else n_state = S_SWEEP;
                    end
                endcase
            end
            S_SWEEP: begin
                if (i_stat.sweep_last) n_state = S_PUT;
            end
            S_PUT:   n_state = S_DONE;
            S_READ:  n_state = S_DONE;
            S_CLEAR: n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd       = '0;
        o_busy      = 1'b1;
        o_res_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_busy    = 1'b0;
                o_cmd.cap = i_start;
            end
            S_DECODE: ;
            S_WRAP: begin
                o_cmd.nl = 1'b1;
            end
            S_KEY: begin
                unique case (i_stat.key_kind)
                    KEY_ENTER: o_cmd.nl = 1'b1;
                    KEY_BKSP:  o_cmd.bksp = !i_stat.col_zero;
                    default: begin
                        o_cmd.sweep_init = !i_stat.char_zero && !i_stat.row_valid;
                    end
                endcase
            end
            S_SWEEP: o_cmd.sweep = 1'b1;
            S_PUT:   o_cmd.put = 1'b1;
            S_READ:  o_cmd.rd = 1'b1;
            S_CLEAR: o_cmd.clear = 1'b1;
            S_DONE:  o_res_valid = 1'b1;
            default: ;
        endcase
    end

endmodule

>>> rtl/tcce_dp.sv
// Datapath of the text console cursor engine: cursor, row ring, cell memory.
`timescale 1ns / 1ps

module tcce_dp
    import tcce_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_req       i_req,
    input  t_cmd       i_cmd,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    output t_stat      o_stat,
    output t_res       o_res
);

    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS + 1);
    localparam int CIW   = $clog2(COLS);
    localparam logic [RW:0]   ROWS_X   = (RW + 1)'(ROWS);
    localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_END  = CW'(COLS);
    localparam logic [CIW-1:0] COL_LAST = CIW'(COLS - 1);
    localparam logic [AW-1:0] COLS_A   = AW'(COLS);

    // Logical row to physical row of the ring
    function automatic logic [RW-1:0] f_phys(input logic [RW-1:0] top,
                                             input logic [RW-1:0] lr);
        logic [RW:0] sum;
        sum = {1'b0, top} + {1'b0, lr};
        if (sum >= ROWS_X) sum = sum - ROWS_X;
        return sum[RW-1:0];
    endfunction

    t_req            r_req;
    logic [7:0]      r_color;
    logic [RW-1:0]   r_row, n_row;
    logic [CW-1:0]   r_col, n_col;
    logic [RW-1:0]   r_top, n_top;
    logic [ROWS-1:0] r_valid, n_valid;
    logic            r_scrolled, n_scrolled;
    logic [CIW-1:0]  r_sweep_col;
    logic [15:0]     r_rdata;
    logic            r_rd_ok;
    logic [15:0]     mem [DEPTH];

    logic [RW-1:0]   phys_cur;
    logic [RW-1:0]   top_inc;
    logic [AW-1:0]   base_cur;
    logic [CW-1:0]   col_dec;
    logic [7:0]      ch_lo;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [15:0]     wr_data;
    logic            rd_in_range;
    logic [RW-1:0]   rd_phys;
    logic [AW-1:0]   rd_addr;
    logic            rd_ok;

    assign phys_cur = f_phys(r_top, r_row);
    assign top_inc  = (r_top == ROW_LAST) ? '0 : r_top + RW'(1);
    assign base_cur = AW'(phys_cur) * COLS_A;
    assign col_dec  = r_col - CW'(1);
    assign ch_lo    = (r_req.char_code == CH_CR) ? CH_NONE : r_req.char_code;

    // Cursor, ring top and row valid bits
    always_comb begin
        n_row      = r_row;
        n_col      = r_col;
        n_top      = r_top;
        n_valid    = r_valid;
        n_scrolled = r_scrolled;
        if (i_cmd.cap) n_scrolled = 1'b0;
        if (i_cmd.nl) begin
            if (r_row != ROW_LAST) begin
                n_row = r_row + RW'(1);
            end else begin
                // old top row becomes the blank bottom row
                n_top          = top_inc;
                n_valid[r_top] = 1'b0;
                n_scrolled     = 1'b1;
            end
            n_col = '0;
        end
        if (i_cmd.bksp) n_col = col_dec;
        if (i_cmd.put) begin
            n_col             = r_col + CW'(1);
            n_valid[phys_cur] = 1'b1;
        end
        if (i_cmd.clear) begin
            n_row   = '0;
            n_col   = '0;
            n_top   = '0;
            n_valid = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_top      <= '0;
            r_valid    <= '0;
            r_scrolled <= 1'b0;
            r_color    <= TEXT_COLOR_RST;
        end else begin
            r_row      <= n_row;
            r_col      <= n_col;
            r_top      <= n_top;
            r_valid    <= n_valid;
            r_scrolled <= n_scrolled;
            if (i_cfg_we) r_color <= i_cfg_data;
        end
    end

    // Request latch and row blanking counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) r_req <= i_req;
        if (i_cmd.sweep_init) r_sweep_col <= '0;
        else if (i_cmd.sweep) r_sweep_col <= r_sweep_col + CIW'(1);
    end

    // Write port select
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = base_cur + AW'(r_col);
        wr_data = '0;
        if (i_cmd.sweep) begin
            wr_en   = 1'b1;
            wr_addr = base_cur + AW'(r_sweep_col);
        end
        if (i_cmd.bksp) begin
            // an invalid row already reads as blank
            wr_en   = r_valid[phys_cur];
            wr_addr = base_cur + AW'(col_dec);
        end
        if (i_cmd.put) begin
            wr_en   = 1'b1;
            wr_addr = base_cur + AW'(r_col);
            wr_data = {r_color, ch_lo};
        end
    end

    // Read port address
    assign rd_in_range = (32'(r_req.read_row) < ROWS) && (32'(r_req.read_col) < COLS);
    assign rd_phys     = f_phys(r_top, RW'(r_req.read_row));
    assign rd_addr     = rd_in_range ? AW'(rd_phys) * COLS_A + AW'(r_req.read_col) : '0;
    assign rd_ok       = rd_in_range && r_valid[rd_phys];

    // Cell memory
    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (i_cmd.rd) begin
            r_rdata <= mem[rd_addr];
            r_rd_ok <= rd_ok;
        end
    end

    // Status to controller
    assign o_stat.opcode       = r_req.opcode;
    assign o_stat.key_kind     = r_req.key_kind;
    assign o_stat.char_zero    = (r_req.char_code == CH_NONE);
    assign o_stat.wrap_pending = (r_col == COL_END);
    assign o_stat.col_zero     = (r_col == '0);
    assign o_stat.row_valid    = r_valid[phys_cur];
    assign o_stat.sweep_last   = (r_sweep_col == COL_LAST);

    // Result fields
    assign o_res.cursor_row = 5'(r_row);
    assign o_res.cursor_col = 7'(r_col);
    assign o_res.scrolled   = r_scrolled;
    assign o_res.cell_data  = (r_req.opcode == OP_READ && r_rd_ok) ? r_rdata : '0;

endmodule

>>> rtl/text_console_cursor_engine_unit.sv
// Top level of the text console cursor engine.
//
//  channel   direction  handshake               payload
//  request   in         start / busy            i_req  (t_req)
//  result    out        o_res_valid strobe      o_res  (t_res)
//  config    in         i_cfg_valid/o_cfg_ready i_cfg_data (text color)
//
// Accept to strobe: S_DECODE; S_WRAP on a pending wrap; S_KEY, S_READ or
// S_CLEAR (none for an unknown opcode); S_PUT for a stored character; S_DONE.
// A character on a row not yet written first blanks that row one cell per
// cycle through the single write port (S_SWEEP) before S_PUT.
// Scrolling moves a row ring pointer; reset clears the row valid bits, so
// there is no clearing pass. Busy drops after the strobe; results never stall.
`timescale 1ns / 1ps

module text_console_cursor_engine_unit
    import tcce_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_req       i_req,
    output logic       o_res_valid,
    output t_res       o_res,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;
    logic  cfg_we;

    // Config writes only between requests
    assign o_cfg_ready = !busy;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    tcce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_busy      (busy),
        .o_res_valid (o_res_valid)
    );

    tcce_dp #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cmd      (cmd),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_stat     (stat),
        .o_res      (o_res)
    );

`ifndef NO_ASSERTIONS
    // Accepted request keeps the block busy and gives no result next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && !o_res_valid)
        else $error("request accepted but block not busy");

    // After the result strobe the block is free again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !busy && !o_res_valid)
        else $error("block still busy after result");

    // Strobe only while busy
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> busy)
        else $error("result strobe while idle");

    // Reported column never passes the wrap position
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> 32'(o_res.cursor_col) <= COLS)
        else $error("cursor column out of range");
`endif

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the text console cursor engine.
`timescale 1ns / 1ps

module tb;
    import tcce_pkg::*;

    localparam int COLS = 80;
    localparam int ROWS = 25;
    localparam int NUM_ITEMS = 1950;
    localparam int MAX_REPORTS = 10;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_req       i_req;
    logic       o_res_valid;
    t_res       o_res;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data;

    text_console_cursor_engine_unit #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_res_valid(o_res_valid),
        .o_res      (o_res),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    // Directed row: request plus an optional hand-written expected result
    typedef struct {
        t_req req;
        bit   typed;
        t_res res;
    } t_row;

    // Shadow copy of the screen, cursor and attribute
    logic [15:0] screen [ROWS*COLS];
    int unsigned cur_row;
    int unsigned cur_col;
    logic [7:0]  attr;

    t_res cursor_report_q [$];
    t_row directed_q [$];
    t_res want;

    int unsigned n_items;
    int unsigned n_results;
    int unsigned n_err;
    int unsigned n_scroll;
    int unsigned n_wrap;
    int unsigned n_reads;
    int unsigned n_cfg;
    bit          no_idle;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run limit, far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Cursor to the start of the next line, scrolling on the bottom row
    function automatic bit line_feed();
        int i;
        bit s;
        s = 1'b0;
        if (cur_row < ROWS - 1) begin
            cur_row++;
        end else begin
            for (i = 0; i < (ROWS - 1) * COLS; i++) screen[i] = screen[i + COLS];
            for (i = 0; i < COLS; i++) screen[(ROWS - 1) * COLS + i] = 16'h0000;
            s = 1'b1;
        end
        cur_col = 0;
        return s;
    endfunction

    // Apply one request to the shadow console and build its cursor report
    function automatic t_res console_apply(input t_req r);
        t_res o;
        bit   sc;
        int   i;
        logic [15:0] data;
        sc   = 1'b0;
        data = 16'h0000;
        case (r.opcode)
            OP_KEY: begin
                if (cur_col >= COLS) begin
                    sc |= line_feed();
                    n_wrap++;
                end
                if (r.key_kind == KEY_ENTER) begin
                    sc |= line_feed();
                end else if (r.key_kind == KEY_BKSP) begin
                    if (cur_col > 0) begin
                        cur_col--;
                        screen[cur_row * COLS + cur_col] = 16'h0000;
                    end
                end else if (r.char_code != CH_NONE) begin
                    screen[cur_row * COLS + cur_col] =
                        {attr, (r.char_code == CH_CR) ? 8'h00 : r.char_code};
                    cur_col++;
                end
            end
            OP_READ: begin
                n_reads++;
                if (r.read_row < ROWS && r.read_col < COLS)
                    data = screen[r.read_row * COLS + r.read_col];
            end
            OP_CLEAR: begin
                for (i = 0; i < ROWS * COLS; i++) screen[i] = 16'h0000;
                cur_row = 0;
                cur_col = 0;
            end
            default: ;
        endcase
        if (sc) n_scroll++;
        o.cursor_row = 5'(cur_row);
        o.cursor_col = 7'(cur_col);
        o.scrolled   = sc;
        o.cell_data  = data;
        return o;
    endfunction

    function automatic t_req req_of(input logic [1:0] op, input logic [1:0] kind,
                                    input logic [7:0] ch, input logic [4:0] rr,
                                    input logic [6:0] rc);
        t_req r;
        r.opcode    = op;
        r.key_kind  = kind;
        r.char_code = ch;
        r.read_row  = rr;
        r.read_col  = rc;
        return r;
    endfunction

    function automatic t_res res_of(input logic [4:0] row, input logic [6:0] col,
                                    input logic sc, input logic [15:0] data);
        t_res o;
        o.cursor_row = row;
        o.cursor_col = col;
        o.scrolled   = sc;
        o.cell_data  = data;
        return o;
    endfunction

    // Key request with random noise on the unused read fields
    function automatic t_req key_req(input logic [1:0] kind, input logic [7:0] ch);
        return req_of(OP_KEY, kind, ch, 5'($urandom_range(0, 31)),
                      7'($urandom_range(0, 127)));
    endfunction

    // Mostly printable characters, now and then the ignored and CR codes
    function automatic logic [7:0] rand_char();
        int unsigned p;
        p = $urandom_range(0, 15);
        if (p == 0) return CH_NONE;
        if (p == 1) return CH_CR;
        return 8'($urandom_range(1, 255));
    endfunction

    // Issue one request, predict it at the accepting edge
    task automatic send(input t_req r, input bit typed, input t_res res);
        int unsigned gap;
        t_res p;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        p = console_apply(r);
        cursor_report_q.push_back(typed ? res : p);
        n_items++;
    endtask

    task automatic send_rand(input t_req r);
        send(r, 1'b0, '0);
    endtask

    // Drop start and wait until the engine has nothing in flight
    task automatic go_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (cursor_report_q.size() != 0 || busy) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // Write the text color register while idle
    task automatic write_color(input logic [7:0] v);
        go_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        attr = v;
        n_cfg++;
    endtask

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) begin
            n_results++;
            if (cursor_report_q.size() == 0) begin
                n_err++;
                if (n_err <= MAX_REPORTS) begin
                    $write("%0t: result with nothing expected:", $time);
                    $display(" row %0d col %0d scr %0b data %h", o_res.cursor_row,
                             o_res.cursor_col, o_res.scrolled, o_res.cell_data);
                end
            end else begin
                want = cursor_report_q.pop_front();
                if (o_res.cursor_row !== want.cursor_row ||
                    o_res.cursor_col !== want.cursor_col ||
                    o_res.scrolled   !== want.scrolled ||
                    o_res.cell_data  !== want.cell_data) begin
                    n_err++;
                    if (n_err <= MAX_REPORTS) begin
                        $write("%0t: mismatch exp row %0d col %0d scr %0b data %h", $time,
                               want.cursor_row, want.cursor_col, want.scrolled,
                               want.cell_data);
                        $display(" / got row %0d col %0d scr %0b data %h", o_res.cursor_row,
                                 o_res.cursor_col, o_res.scrolled, o_res.cell_data);
                    end
                end
            end
        end
    end

    // Stimulus
    initial begin
        int unsigned burst;
        int unsigned n;
        int unsigned k;
        int unsigned p;
        t_req r;

        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_req       <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 8'h00;
        for (int i = 0; i < ROWS * COLS; i++) screen[i] = 16'h0000;
        cur_row   = 0;
        cur_col   = 0;
        attr      = TEXT_COLOR_RST;
        n_items   = 0;
        n_results = 0;
        n_err     = 0;
        n_scroll  = 0;
        n_wrap    = 0;
        n_reads   = 0;
        n_cfg     = 0;
        no_idle   = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, reset attribute 0x0F
        directed_q.push_back('{req_of(OP_READ, KEY_CHAR, 8'h00, 5'd0, 7'd0), 1'b1,
                               res_of(5'd0, 7'd0, 1'b0, 16'h0000)});
        directed_q.push_back('{req_of(OP_READ, KEY_CHAR, 8'h00, 5'd31, 7'd127), 1'b1,
                               res_of(5'd0, 7'd0, 1'b0, 16'h0000)});
        // unknown opcode: no operation
        directed_q.push_back('{req_of(2'd3, 2'd3, 8'hFF, 5'd31, 7'd127), 1'b1,
                               res_of(5'd0, 7'd0, 1'b0, 16'h0000)});
        directed_q.push_back('{req_of(OP_KEY, KEY_CHAR, 8'h41, 5'd0, 7'd0), 1'b1,
                               res_of(5'd0, 7'd1, 1'b0, 16'h0000)});
        // character 0 is ignored
        directed_q.push_back('{req_of(OP_KEY, KEY_CHAR, CH_NONE, 5'd0, 7'd0), 1'b1,
                               res_of(5'd0, 7'd1, 1'b0, 16'h0000)});
        // CR stores a zero low byte
        directed_q.push_back('{req_of(OP_KEY, KEY_CHAR, CH_CR, 5'd0, 7'd0), 1'b1,
                               res_of(5'd0, 7'd2, 1'b0, 16'h0000)});
        directed_q.push_back('{req_of(OP_KEY, KEY_CHAR, 8'hFF, 5'd31, 7'd127), 1'b1,
                               res_of(5'd0, 7'd3, 1'b0, 16'h0000)});
        directed_q.push_back('{req_of(OP_READ, KEY_CHAR, 8'h00, 5'd0, 7'd0), 1'b1,
                               res_of(5'd0, 7'd3, 1'b0, 16'h0F41)});
        directed_q.push_back('{req_of(OP_READ, KEY_CHAR, 8'h00, 5'd0, 7'd1), 1'b1,
                               res_of(5'd0, 7'd3, 1'b0, 16'h0F00)});
        directed_q.push_back('{req_of(OP_READ, KEY_CHAR, 8'h00, 5'd0, 7'd2), 1'b1,
                               res_of(5'd0, 7'd3, 1'b0, 16'h0FFF)});
        directed_q.push_back('{req_of(OP_KEY, KEY_BKSP, 8'h00, 5'd0, 7'd0), 1'b1,
                               res_of(5'd0, 7'd2, 1'b0, 16'h0000)});
        directed_q.push_back('{req_of(OP_READ, KEY_CHAR, 8'h00, 5'd0, 7'd2), 1'b1,
                               res_of(5'd0, 7'd2, 1'b0, 16'h0000)});
        directed_q.push_back('{req_of(OP_KEY, KEY_ENTER, 8'h00, 5'd0, 7'd0), 1'b1,
                               res_of(5'd1, 7'd0, 1'b0, 16'h0000)});
        // backspace at column zero does nothing
        directed_q.push_back('{req_of(OP_KEY, KEY_BKSP, 8'h00, 5'd0, 7'd0), 1'b1,
                               res_of(5'd1, 7'd0, 1'b0, 16'h0000)});
        // unknown key kind acts as a character
        directed_q.push_back('{req_of(OP_KEY, 2'd3, 8'h80, 5'd0, 7'd0), 1'b1,
                               res_of(5'd1, 7'd1, 1'b0, 16'h0000)});
        directed_q.push_back('{req_of(OP_READ, KEY_CHAR, 8'h00, 5'd1, 7'd0), 1'b1,
                               res_of(5'd1, 7'd1, 1'b0, 16'h0F80)});
        // reads just past the last column and the last row
        directed_q.push_back('{req_of(OP_READ, KEY_CHAR, 8'h00, 5'd24, 7'd80), 1'b1,
                               res_of(5'd1, 7'd1, 1'b0, 16'h0000)});
        directed_q.push_back('{req_of(OP_READ, KEY_CHAR, 8'h00, 5'd25, 7'd0), 1'b1,
                               res_of(5'd1, 7'd1, 1'b0, 16'h0000)});
        directed_q.push_back('{req_of(OP_CLEAR, KEY_CHAR, 8'h00, 5'd0, 7'd0), 1'b1,
                               res_of(5'd0, 7'd0, 1'b0, 16'h0000)});
        directed_q.push_back('{req_of(OP_READ, KEY_CHAR, 8'h00, 5'd0, 7'd0), 1'b1,
                               res_of(5'd0, 7'd0, 1'b0, 16'h0000)});
        directed_q.push_back('{req_of(OP_READ, KEY_CHAR, 8'h00, 5'd24, 7'd79), 1'b1,
                               res_of(5'd0, 7'd0, 1'b0, 16'h0000)});
        directed_q.push_back('{req_of(OP_KEY, KEY_CHAR, 8'h7E, 5'd0, 7'd0), 1'b0, '0});
        directed_q.push_back('{req_of(OP_READ, KEY_CHAR, 8'h00, 5'd0, 7'd0), 1'b0, '0});

        foreach (directed_q[i]) send(directed_q[i].req, directed_q[i].typed, directed_q[i].res);

        write_color(8'hFF);

        // Random bursts of console traffic
        while (n_items < NUM_ITEMS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            burst   = $urandom_range(0, 99);
            if (burst < 35) begin
                // free typing
                n = $urandom_range(1, 24);
                for (k = 0; k < n; k++)
                    send_rand(key_req(($urandom_range(0, 15) == 0) ? 2'd3 : KEY_CHAR,
                                      rand_char()));
            end else if (burst < 50) begin
                // type to the end of the line, then one key on the pending wrap
                n = (cur_col >= COLS) ? 0 : COLS - cur_col;
                for (k = 0; k < n; k++) send_rand(key_req(KEY_CHAR, 8'($urandom_range(1, 255))));
                send_rand(key_req(2'($urandom_range(0, 3)), rand_char()));
            end else if (burst < 63) begin
                n = $urandom_range(1, 10);
                for (k = 0; k < n; k++) send_rand(key_req(KEY_ENTER, rand_char()));
            end else if (burst < 72) begin
                n = $urandom_range(1, 10);
                for (k = 0; k < n; k++) send_rand(key_req(KEY_BKSP, rand_char()));
            end else if (burst < 88) begin
                n = $urandom_range(1, 6);
                for (k = 0; k < n; k++) begin
                    r = req_of(OP_READ, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                               5'($urandom_range(0, ROWS - 1)),
                               7'($urandom_range(0, COLS - 1)));
                    p = $urandom_range(0, 3);
                    if (p == 0) begin
                        // around the cursor
                        r.read_row = 5'(cur_row);
                        r.read_col = 7'((cur_col == 0) ? 0 : cur_col - 1);
                    end else if (p == 1) begin
                        r.read_row = 5'($urandom_range(0, 31));
                        r.read_col = 7'($urandom_range(0, 127));
                    end
                    send_rand(r);
                end
            end else if (burst < 94) begin
                // raw noise, clears kept rare
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++) begin
                    r = req_of(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                               8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                               7'($urandom_range(0, 127)));
                    if (r.opcode == OP_CLEAR && $urandom_range(0, 7) != 0) r.opcode = 2'd3;
                    send_rand(r);
                end
            end else if (burst < 95) begin
                send_rand(req_of(OP_CLEAR, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127))));
            end else begin
                // cycle through zero, a random value and all ones
                case (n_cfg % 3)
                    1: write_color(8'h00);
                    2: write_color(8'($urandom_range(1, 254)));
                    default: write_color(8'hFF);
                endcase
            end
        end

        go_idle();
        repeat (COLS + 10) @(posedge i_clk);

        $display("Covered %0d requests, %0d results, %0d reads, %0d color writes",
                 n_items, n_results, n_reads, n_cfg);
        $display("Deferred wraps taken: %0d, scrolls: %0d, mismatches: %0d",
                 n_wrap, n_scroll, n_err);
        if (n_err == 0 && cursor_report_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            if (cursor_report_q.size() != 0)
                $display("%0d expected results never arrived", cursor_report_q.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
